// File: hdl/sdtb_pkg.sv
// Shared types, constants and small lookup functions for the sparse
// decimal to binary converter. Depends on nothing else.
package sdtb_pkg;

  localparam int WORD_W    = 32;
  localparam int ACC_W     = 192;
  localparam int CHUNK_W   = 64;
  localparam int DIGIT_W   = 8;
  localparam int BASE_W    = 30;
  localparam int DIV_W     = 27;
  localparam int SCALE_W   = 6;
  localparam int FRAC_W    = 4;
  localparam int CNT_W     = $clog2(ACC_W);
  localparam int MAC_STEPS = ACC_W / DIGIT_W;
  localparam int DIV_STEPS = ACC_W;
  localparam int NUM_CHUNKS = ACC_W / CHUNK_W;
  localparam int IDX_W     = 2;

  localparam logic [BASE_W-1:0] GROUP_BASE = 30'd1000000000;
  localparam int                SIGN_BIT   = 31;
  localparam logic [WORD_W-1:0] VALUE_MASK = 32'h7FFF_FFFF;
  localparam logic [FRAC_W-1:0] GROUP_DIGITS = 4'd9;

  // configuration register indexes
  localparam logic REG_SCALE = 1'b0;
  localparam logic REG_TRUNC = 1'b1;

  typedef struct packed {
    logic load;
    logic step;
  } sdtb_ctl_t;

  // scale mod 9 by compare and subtract; input is below 64
  function automatic logic [FRAC_W-1:0] frac_digits(input logic [SCALE_W-1:0] s);
    logic [SCALE_W-1:0] x;
    x = s;
    if (x >= 6'd36) x = x - 6'd36;
    if (x >= 6'd18) x = x - 6'd18;
    if (x >= 6'd9)  x = x - 6'd9;
    return x[FRAC_W-1:0];
  endfunction

  // 10^(9 - frac) for the padding digits of the last group; 1 when frac is 0 or above 8
  function automatic logic [DIV_W-1:0] pad_divisor(input logic [FRAC_W-1:0] frac);
    logic [DIV_W-1:0] d;
    case (frac)
      4'd1:    d = 27'd100000000;
      4'd2:    d = 27'd10000000;
      4'd3:    d = 27'd1000000;
      4'd4:    d = 27'd100000;
      4'd5:    d = 27'd10000;
      4'd6:    d = 27'd1000;
      4'd7:    d = 27'd100;
      4'd8:    d = 27'd10;
      default: d = 27'd1;
    endcase
    return d;
  endfunction

endpackage

// File: hdl/sdtb_mac.sv
// Byte-serial multiply by 1e9 with add, least significant byte first.
// Depends on sdtb_pkg.
module sdtb_mac (
  input  logic                             clk,
  input  sdtb_pkg::sdtb_ctl_t              ctl,
  input  logic [sdtb_pkg::WORD_W-1:0]      addend,
  input  logic [sdtb_pkg::DIGIT_W-1:0]     digit_in,
  output logic [sdtb_pkg::DIGIT_W-1:0]     digit_out
);

  localparam int P_W = sdtb_pkg::DIGIT_W + sdtb_pkg::BASE_W + 1;

  logic [sdtb_pkg::WORD_W-1:0] carry;
  logic [P_W-1:0]              prod;

  // byte * 1e9 + carry stays below 2^39
  assign prod = P_W'(digit_in) * P_W'(sdtb_pkg::GROUP_BASE) + P_W'(carry);
  assign digit_out = prod[sdtb_pkg::DIGIT_W-1:0];

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      carry <= addend;
    end else if (ctl.step) begin
      carry <= sdtb_pkg::WORD_W'(prod[P_W-1:sdtb_pkg::DIGIT_W]);
    end
  end

endmodule

// File: hdl/sdtb_div.sv
// Bit-serial restoring division by the divisor input, most significant bit first.
// Depends on sdtb_pkg.
module sdtb_div (
  input  logic                           clk,
  input  sdtb_pkg::sdtb_ctl_t            ctl,
  input  logic [sdtb_pkg::DIV_W-1:0]     divisor,
  input  logic                           bit_in,
  output logic                           q_bit
);

  logic [sdtb_pkg::DIV_W-1:0] rem;
  logic [sdtb_pkg::DIV_W:0]   partial;
  logic [sdtb_pkg::DIV_W:0]   diff;

  assign partial = {rem, bit_in};
  assign diff    = partial - {1'b0, divisor};
  assign q_bit   = (partial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rem <= '0;
    end else if (ctl.step) begin
      rem <= q_bit ? diff[sdtb_pkg::DIV_W-1:0] : partial[sdtb_pkg::DIV_W-1:0];
    end
  end

endmodule

// File: hdl/sparse_decimal_to_binary_top.sv
// Top level of the sparse decimal to binary converter: controller, 192-bit
// accumulator shift register and result registers. Uses sdtb_pkg, sdtb_mac, sdtb_div.
//
//  channel  | signals                                   | transfer
//  ---------+-------------------------------------------+------------------------
//  input    | start, busy, word, last_word              | start && !busy
//  result   | result_valid, chunk, chunk_index,         | result_valid (1 cycle)
//           | negative, overflow, last_chunk            |
//  config   | cfg_we, cfg_index, cfg_data               | cfg_we
//
// Steps: the first word of a decimal needs no multiply-add pass; each further word
// runs 24 byte steps of the multiply-add unit through the accumulator.
// A word past MAX_WORDS skips the pass. On the last word the tail adds a
// bit-serial division over all 192 accumulator bits when truncation applies, a
// finish state to settle the sign and three chunks. Reset is synchronous and clears control state.
// The receiver cannot stall: each chunk is on the ports for one cycle only.
module sparse_decimal_to_binary_top #(
  parameter int MAX_WORDS = 6
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [sdtb_pkg::WORD_W-1:0]       word,
  input  logic                              last_word,
  output logic                              result_valid,
  output logic [sdtb_pkg::CHUNK_W-1:0]      chunk,
  output logic [sdtb_pkg::IDX_W-1:0]        chunk_index,
  output logic                              negative,
  output logic                              overflow,
  output logic                              last_chunk,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [sdtb_pkg::SCALE_W-1:0]      cfg_data
);

  localparam int WS_W = $clog2(MAX_WORDS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DIV,
    ST_FINISH,
    ST_EMIT
  } state_t;

  state_t                        state;
  logic [sdtb_pkg::ACC_W-1:0]    acc;
  logic [sdtb_pkg::CNT_W-1:0]    cnt;
  logic [WS_W-1:0]               words_seen;
  logic                          sign_flag;
  logic                          overflow_flag;
  logic                          last_pending;
  logic [sdtb_pkg::IDX_W-1:0]    emit_idx;

  logic [sdtb_pkg::SCALE_W-1:0]  scale;
  logic                          truncate_enable;

  logic                          accept;
  logic                          trunc_on;
  logic [sdtb_pkg::FRAC_W-1:0]   frac;
  logic [sdtb_pkg::DIV_W-1:0]    divisor;
  logic                          mac_start;
  logic                          tail_now;
  logic                          go_div;
  logic                          mac_done;
  logic                          div_done;

  sdtb_pkg::sdtb_ctl_t           mac_ctl;
  sdtb_pkg::sdtb_ctl_t           div_ctl;
  logic [sdtb_pkg::DIGIT_W-1:0]  mac_digit;
  logic                          div_q;

  // Configuration writes land at once; the user must write only while idle, the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      scale           <= '0;
      truncate_enable <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        sdtb_pkg::REG_SCALE: scale           <= cfg_data;
        sdtb_pkg::REG_TRUNC: truncate_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign frac     = sdtb_pkg::frac_digits(scale);
  assign divisor  = sdtb_pkg::pad_divisor(frac);
  assign trunc_on = truncate_enable && (frac != '0);

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign mac_done = (cnt == sdtb_pkg::CNT_W'(sdtb_pkg::MAC_STEPS - 1));
  assign div_done = (cnt == sdtb_pkg::CNT_W'(sdtb_pkg::DIV_STEPS - 1));

  // A word needs the multiply-add pass unless it opens the decimal or is past capacity.
  assign mac_start = accept && (words_seen != '0) && (words_seen < WS_W'(MAX_WORDS));
  // The tail begins right away on a last word that skips the pass, or when the pass ends.
  assign tail_now  = (accept && last_word && !mac_start)
                  || ((state == ST_MAC) && mac_done && last_pending);
  assign go_div    = tail_now && trunc_on;

  always_comb begin
    mac_ctl.load = mac_start;
    mac_ctl.step = (state == ST_MAC);
    div_ctl.load = go_div;
    div_ctl.step = (state == ST_DIV);
  end

  sdtb_mac u_mac (
    .clk       (clk),
    .ctl       (mac_ctl),
    .addend    (word),
    .digit_in  (acc[sdtb_pkg::DIGIT_W-1:0]),
    .digit_out (mac_digit)
  );

  sdtb_div u_div (
    .clk     (clk),
    .ctl     (div_ctl),
    .divisor (divisor),
    .bit_in  (acc[sdtb_pkg::ACC_W-1]),
    .q_bit   (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      cnt           <= '0;
      words_seen    <= '0;
      sign_flag     <= 1'b0;
      overflow_flag <= 1'b0;
      last_pending  <= 1'b0;
      emit_idx      <= '0;
      result_valid  <= 1'b0;
    end else begin
      // a chunk leaves in the cycle after each emit step
      result_valid <= (state == ST_EMIT);
      case (state)
        ST_IDLE: begin
          if (accept) begin
            last_pending <= last_word;
            cnt          <= '0;
            if (words_seen == '0) begin
              // opening word: drop the sign bit into its flag
              sign_flag  <= word[sdtb_pkg::SIGN_BIT];
              acc        <= sdtb_pkg::ACC_W'(word & sdtb_pkg::VALUE_MASK);
              words_seen <= WS_W'(1);
            end else if (mac_start) begin
              words_seen <= words_seen + WS_W'(1);
            end else begin
              overflow_flag <= 1'b1;
            end
            if (mac_start) begin
              state <= ST_MAC;
            end else if (last_word) begin
              state <= go_div ? ST_DIV : ST_FINISH;
            end
          end
        end
        ST_MAC: begin
          // rotate one product byte into the top, low byte out to the unit
          acc <= {mac_digit, acc[sdtb_pkg::ACC_W-1:sdtb_pkg::DIGIT_W]};
          if (mac_done) begin
            cnt <= '0;
            if (last_pending) begin
              state <= go_div ? ST_DIV : ST_FINISH;
            end else begin
              state <= ST_IDLE;
            end
          end else begin
            cnt <= cnt + sdtb_pkg::CNT_W'(1);
          end
        end
        ST_DIV: begin
          // shift the dividend out at the top, quotient bits in at the bottom
          acc <= {acc[sdtb_pkg::ACC_W-2:0], div_q};
          if (div_done) begin
            cnt   <= '0;
            state <= ST_FINISH;
          end else begin
            cnt <= cnt + sdtb_pkg::CNT_W'(1);
          end
        end
        ST_FINISH: begin
          // a zero magnitude never reads as negative
          negative <= sign_flag && (|acc);
          overflow <= overflow_flag;
          emit_idx <= '0;
          state    <= ST_EMIT;
        end
        ST_EMIT: begin
          chunk        <= acc[sdtb_pkg::CHUNK_W-1:0];
          chunk_index  <= emit_idx;
          last_chunk   <= (emit_idx == sdtb_pkg::IDX_W'(sdtb_pkg::NUM_CHUNKS - 1));
          acc          <= acc >> sdtb_pkg::CHUNK_W;
          emit_idx     <= emit_idx + sdtb_pkg::IDX_W'(1);
          if (emit_idx == sdtb_pkg::IDX_W'(sdtb_pkg::NUM_CHUNKS - 1)) begin
            words_seen    <= '0;
            sign_flag     <= 1'b0;
            overflow_flag <= 1'b0;
            last_pending  <= 1'b0;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Chunks of one decimal come in consecutive cycles.
  a_chunks_back_to_back: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last_chunk |=> result_valid)
    else $error("chunk stream broke before the last chunk");

  // A chunk run always opens at the least significant slice.
  a_run_starts_low: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> (chunk_index == '0))
    else $error("chunk run did not start at index zero");

  // The final slice carries the top index.
  a_last_is_top: assert property (@(posedge clk) disable iff (rst)
    result_valid && last_chunk |-> (chunk_index == sdtb_pkg::IDX_W'(sdtb_pkg::NUM_CHUNKS - 1)))
    else $error("last chunk flag on wrong slice");

  // Sign and overflow hold across the chunks of one decimal.
  a_flags_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && (chunk_index != '0) |-> $stable(negative) && $stable(overflow))
    else $error("flags changed within a chunk run");

  // The divider only runs when truncation applies.
  a_div_needs_trunc: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> trunc_on)
    else $error("division pass without truncation");

endmodule

// File: bench/sparse_decimal_to_binary_top_tb.sv
// Self-checking testbench for sparse_decimal_to_binary_top: directed table, then random decimals.
// Runs its own model of the base-1e9 accumulator and checks every chunk.
// Depends on sdtb_pkg and sparse_decimal_to_binary_top.
module sparse_decimal_to_binary_top_tb;

  localparam int DEC_MAX_WORDS = 6;
  // Cycles to let pass once the last chunk is in: worst word plus division tail.
  localparam int DRAIN_CYCLES  = 260;
  localparam int PHASE_ITEMS   = 13;

  typedef struct packed {
    logic [sdtb_pkg::CHUNK_W-1:0] chunk;
    logic [sdtb_pkg::IDX_W-1:0]   idx;
    logic                         neg;
    logic                         ovf;
    logic                         last;
  } chunk_t;

  typedef enum logic [1:0] {ROW_WORD, ROW_SCALE, ROW_TRUNC} row_kind_t;

  // One row of the directed table. Rows with typed set carry the expected low chunk
  // and sign; the upper chunks are then zero.
  typedef struct packed {
    row_kind_t                    kind;
    logic [sdtb_pkg::WORD_W-1:0]  data;
    logic                         last;
    logic                         typed;
    logic [sdtb_pkg::CHUNK_W-1:0] exp_lo;
    logic                         exp_neg;
  } dir_row_t;

  logic                          clk;
  logic                          rst;
  logic                          start;
  logic                          busy;
  logic [sdtb_pkg::WORD_W-1:0]   word;
  logic                          last_word;
  logic                          result_valid;
  logic [sdtb_pkg::CHUNK_W-1:0]  chunk;
  logic [sdtb_pkg::IDX_W-1:0]    chunk_index;
  logic                          negative;
  logic                          overflow;
  logic                          last_chunk;
  logic                          cfg_we;
  logic                          cfg_index;
  logic [sdtb_pkg::SCALE_W-1:0]  cfg_data;

  // Model state: the 192-bit magnitude being built and the register copies.
  logic [sdtb_pkg::ACC_W-1:0]    mag_acc;
  logic                          mag_sign;
  int                            mag_words;
  logic                          mag_ovf;
  logic [sdtb_pkg::SCALE_W-1:0]  scale_reg;
  logic                          trunc_reg;

  chunk_t               pending_chunks[$];
  int                   errors;
  int                   items_sent;
  int                   chunks_checked;
  int                   decimals_sent;
  int                   cfg_writes;
  bit                   idle_enabled;

  sparse_decimal_to_binary_top #(
    .MAX_WORDS(DEC_MAX_WORDS)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .word        (word),
    .last_word   (last_word),
    .result_valid(result_valid),
    .chunk       (chunk),
    .chunk_index (chunk_index),
    .negative    (negative),
    .overflow    (overflow),
    .last_chunk  (last_chunk),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #3000000;
    $display("Simulation FAILED");
    $finish;
  end

  // Fold one accepted word into the magnitude. On a last word, work out the
  // three chunks and queue them, then clear the decimal state.
  task automatic absorb_word(input logic [sdtb_pkg::WORD_W-1:0] w, input logic lst,
                             input logic typed,
                             input logic [sdtb_pkg::CHUNK_W-1:0] typed_lo,
                             input logic typed_neg);
    chunk_t                     r;
    logic [sdtb_pkg::ACC_W-1:0] divisor;
    logic                       neg;
    int                         frac;
    int                         k;
    if (mag_words == 0) begin
      // first word: bit 31 is the sign, the rest is the top digit group
      mag_sign  = w[sdtb_pkg::SIGN_BIT];
      mag_acc   = '0;
      mag_acc[sdtb_pkg::WORD_W-1:0] = w & sdtb_pkg::VALUE_MASK;
      mag_words = 1;
    end else if (mag_words < DEC_MAX_WORDS) begin
      // oversized groups are added as they are, wrapping at 192 bits
      mag_acc   = mag_acc * 192'd1000000000
                + {{(sdtb_pkg::ACC_W-sdtb_pkg::WORD_W){1'b0}}, w};
      mag_words = mag_words + 1;
    end else begin
      // past capacity: drop the word, flag it
      mag_ovf = 1'b1;
    end
    if (lst) begin
      frac = int'(scale_reg) % 9;
      if (trunc_reg && frac != 0) begin
        divisor = sdtb_pkg::ACC_W'(1);
        repeat (9 - frac) divisor = divisor * sdtb_pkg::ACC_W'(10);
        mag_acc = mag_acc / divisor;
      end
      // no negative zero, also when truncation wiped the value out
      neg = mag_sign && (mag_acc != '0);
      for (k = 0; k < sdtb_pkg::NUM_CHUNKS; k++) begin
        r.chunk = mag_acc[k*sdtb_pkg::CHUNK_W +: sdtb_pkg::CHUNK_W];
        r.idx   = k[sdtb_pkg::IDX_W-1:0];
        r.neg   = neg;
        r.ovf   = mag_ovf;
        r.last  = (k == sdtb_pkg::NUM_CHUNKS - 1);
        if (typed) begin
          r.chunk = (k == 0) ? typed_lo : '0;
          r.neg   = typed_neg;
          r.ovf   = 1'b0;
        end
        pending_chunks.push_back(r);
      end
      mag_acc   = '0;
      mag_sign  = 1'b0;
      mag_words = 0;
      mag_ovf   = 1'b0;
      decimals_sent = decimals_sent + 1;
    end
  endtask

  // Drop start at the next falling edge and put noise on the idle data.
  task automatic release_start();
    @(negedge clk);
    start     = 1'b0;
    word      = $urandom;
    last_word = 1'($urandom_range(0, 1));
  endtask

  // Hold start low for an idle gap of random length.
  task automatic idle_gap();
    int n;
    n = $urandom_range(1, 8);
    release_start();
    repeat (n - 1) @(negedge clk);
  endtask

  // Present one word and hold it until the block takes the transfer.
  task automatic send_word(input logic [sdtb_pkg::WORD_W-1:0] w, input logic lst,
                           input logic typed, input logic [sdtb_pkg::CHUNK_W-1:0] typed_lo,
                           input logic typed_neg);
    if (idle_enabled && $urandom_range(0, 3) == 0) idle_gap();
    @(negedge clk);
    start     = 1'b1;
    word      = w;
    last_word = lst;
    @(posedge clk);
    while (busy) @(posedge clk);
    absorb_word(w, lst, typed, typed_lo, typed_neg);
    items_sent = items_sent + 1;
  endtask

  // Wait until every queued chunk has come, then let the block settle.
  task automatic quiesce();
    release_start();
    while (pending_chunks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write one register; the model copy changes at the same edge.
  task automatic write_reg(input logic idx, input logic [sdtb_pkg::SCALE_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    if (idx == sdtb_pkg::REG_SCALE) scale_reg = val;
    else                            trunc_reg = val[0];
    cfg_writes = cfg_writes + 1;
    @(negedge clk);
    cfg_we   = 1'b0;
    cfg_data = '0;
  endtask

  // Mostly in-range digit groups; sometimes raw words and corner values.
  function automatic logic [sdtb_pkg::WORD_W-1:0] pick_group();
    logic [sdtb_pkg::WORD_W-1:0] g;
    case ($urandom_range(0, 9))
      7: g = $urandom;
      8, 9: begin
        case ($urandom_range(0, 5))
          0: g = 32'h0000_0000;
          1: g = 32'd999999999;
          2: g = 32'd1000000000;
          3: g = 32'hFFFF_FFFF;
          4: g = 32'h7FFF_FFFF;
          default: g = 32'h8000_0000;
        endcase
      end
      default: begin
        g = $urandom_range(0, 999999999);
        g[sdtb_pkg::SIGN_BIT] = 1'($urandom_range(0, 1));
      end
    endcase
    return g;
  endfunction

  // Send one whole decimal; most are within capacity, some run past it.
  task automatic send_decimal();
    int len;
    int i;
    if ($urandom_range(0, 9) < 8) len = $urandom_range(1, DEC_MAX_WORDS);
    else                          len = $urandom_range(DEC_MAX_WORDS + 1, DEC_MAX_WORDS + 3);
    for (i = 0; i < len; i++)
      send_word(pick_group(), i == len - 1, 1'b0, '0, 1'b0);
  endtask

  task automatic report(input string fld, input logic [sdtb_pkg::CHUNK_W-1:0] exp_v,
                        input logic [sdtb_pkg::CHUNK_W-1:0] act_v);
    if (exp_v !== act_v) begin
      errors = errors + 1;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, fld, exp_v, act_v);
    end
  endtask

  // Check every chunk against the oldest expectation; chunks cannot be held off.
  always @(posedge clk) begin
    chunk_t exp_r;
    if (!rst && result_valid) begin
      if (pending_chunks.size() == 0) begin
        errors = errors + 1;
        $display("%0t: unexpected chunk: expected none, actual %h index %0d",
                 $time, chunk, chunk_index);
      end else begin
        exp_r = pending_chunks.pop_front();
        report("chunk", exp_r.chunk, chunk);
        report("chunk_index", 64'(exp_r.idx), 64'(chunk_index));
        report("negative", 64'(exp_r.neg), 64'(negative));
        report("overflow", 64'(exp_r.ovf), 64'(overflow));
        report("last_chunk", 64'(exp_r.last), 64'(last_chunk));
        chunks_checked = chunks_checked + 1;
      end
    end
  end

  initial begin
    dir_row_t                     dir_q[$];
    dir_row_t                     row;
    logic [sdtb_pkg::SCALE_W-1:0] scale_set[6];
    logic                         trunc_set[6];
    int                           i;
    int                           ph;
    int                           phase_start;

    // Drive every input to a known value before the first edge.
    rst       = 1'b1;
    start     = 1'b0;
    word      = '0;
    last_word = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = sdtb_pkg::REG_SCALE;
    cfg_data  = '0;
    errors         = 0;
    items_sent     = 0;
    chunks_checked = 0;
    decimals_sent  = 0;
    cfg_writes     = 0;
    idle_enabled   = 1'b1;
    mag_acc   = '0;
    mag_sign  = 1'b0;
    mag_words = 0;
    mag_ovf   = 1'b0;
    scale_reg = '0;
    trunc_reg = 1'b0;

    // Directed table. Typed rows: values after reset, extremes of the word,
    // negative zero, and truncation down to a readable number.
    dir_q.push_back('{ROW_WORD, 32'h0000_0000, 1'b1, 1'b1, 64'h0, 1'b0});
    dir_q.push_back('{ROW_WORD, 32'h7FFF_FFFF, 1'b1, 1'b1, 64'h7FFF_FFFF, 1'b0});
    dir_q.push_back('{ROW_WORD, 32'hFFFF_FFFF, 1'b1, 1'b1, 64'h7FFF_FFFF, 1'b1});
    dir_q.push_back('{ROW_WORD, 32'h8000_0000, 1'b1, 1'b1, 64'h0, 1'b0});
    // two groups, negative
    dir_q.push_back('{ROW_WORD, 32'h8000_0001, 1'b0, 1'b0, 64'h0, 1'b0});
    dir_q.push_back('{ROW_WORD, 32'd999999999, 1'b1, 1'b0, 64'h0, 1'b0});
    // full capacity of oversized groups
    for (i = 0; i < DEC_MAX_WORDS; i++)
      dir_q.push_back('{ROW_WORD, 32'hFFFF_FFFF, i == DEC_MAX_WORDS - 1, 1'b0, 64'h0, 1'b0});
    // one word past capacity; its last mark still ends the decimal
    for (i = 0; i <= DEC_MAX_WORDS; i++)
      dir_q.push_back('{ROW_WORD, 32'd999999999 - i, i == DEC_MAX_WORDS, 1'b0, 64'h0, 1'b0});
    // scale 38 keeps two digits of the last group: divide by 10^7
    dir_q.push_back('{ROW_SCALE, 32'd38, 1'b0, 1'b0, 64'h0, 1'b0});
    dir_q.push_back('{ROW_TRUNC, 32'd1, 1'b0, 1'b0, 64'h0, 1'b0});
    dir_q.push_back('{ROW_WORD, 32'd123456789, 1'b1, 1'b1, 64'd12, 1'b0});
    dir_q.push_back('{ROW_WORD, 32'h8000_0005, 1'b1, 1'b1, 64'h0, 1'b0});
    // scale 63 is a multiple of nine: nothing to strip
    dir_q.push_back('{ROW_SCALE, 32'd63, 1'b0, 1'b0, 64'h0, 1'b0});
    dir_q.push_back('{ROW_WORD, 32'hFFFF_FFFF, 1'b1, 1'b1, 64'h7FFF_FFFF, 1'b1});
    dir_q.push_back('{ROW_SCALE, 32'd0, 1'b0, 1'b0, 64'h0, 1'b0});
    dir_q.push_back('{ROW_WORD, 32'd42, 1'b1, 1'b1, 64'd42, 1'b0});
    dir_q.push_back('{ROW_SCALE, 32'd8, 1'b0, 1'b0, 64'h0, 1'b0});
    dir_q.push_back('{ROW_WORD, 32'd1, 1'b0, 1'b0, 64'h0, 1'b0});
    dir_q.push_back('{ROW_WORD, 32'd999999999, 1'b1, 1'b0, 64'h0, 1'b0});
    dir_q.push_back('{ROW_TRUNC, 32'd0, 1'b0, 1'b0, 64'h0, 1'b0});
    dir_q.push_back('{ROW_SCALE, 32'd0, 1'b0, 1'b0, 64'h0, 1'b0});

    // Settings of the random phases, extremes among them.
    scale_set[0] = 6'd0;   trunc_set[0] = 1'b1;
    scale_set[1] = 6'd38;  trunc_set[1] = 1'b1;
    scale_set[2] = 6'd1;   trunc_set[2] = 1'b0;
    scale_set[3] = 6'd1;   trunc_set[3] = 1'b1;
    scale_set[4] = 6'd63;  trunc_set[4] = 1'b1;
    scale_set[5] = sdtb_pkg::SCALE_W'($urandom_range(0, 63));
    trunc_set[5] = 1'($urandom_range(0, 1));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Walk the directed table; registers change only with the block idle.
    for (i = 0; i < dir_q.size(); i++) begin
      row = dir_q[i];
      case (row.kind)
        ROW_SCALE: begin
          quiesce();
          write_reg(sdtb_pkg::REG_SCALE, row.data[sdtb_pkg::SCALE_W-1:0]);
        end
        ROW_TRUNC: begin
          quiesce();
          write_reg(sdtb_pkg::REG_TRUNC, row.data[sdtb_pkg::SCALE_W-1:0]);
        end
        default: begin
          send_word(row.data, row.last, row.typed, row.exp_lo, row.exp_neg);
        end
      endcase
    end

    // Random phases: drain fully before each new setting. The last phase
    // runs back to back with no idling.
    for (ph = 0; ph < 6; ph++) begin
      quiesce();
      write_reg(sdtb_pkg::REG_SCALE, scale_set[ph]);
      write_reg(sdtb_pkg::REG_TRUNC, {{(sdtb_pkg::SCALE_W-1){1'b0}}, trunc_set[ph]});
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        idle_enabled = (ph < 5) && ($urandom_range(0, 2) != 0);
        send_decimal();
      end
    end

    release_start();
    while (pending_chunks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d words in %0d decimals, %0d chunks checked, %0d register writes.",
             items_sent, decimals_sent, chunks_checked, cfg_writes);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches found.", errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
